[src/fua_pkg.sv]
// Shared types and constants for the H.264 FU-A fragmenter.
`default_nettype none

package fua_pkg;

  typedef enum logic {
    OP_NEW   = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;
  localparam logic [4:0]  FU_A_TYPE         = 5'd28;
  localparam logic [7:0]  S_BIT             = 8'h80;
  localparam logic [7:0]  E_BIT             = 8'h40;
  localparam int          QUEUE_DEPTH       = 2;

  // One NAL waiting to be packetised
  typedef struct packed {
    logic [7:0]  header;
    logic [15:0] length;
    logic [31:0] timestamp;
    logic        mark;
  } job_t;

  typedef struct packed {
    logic en;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

`default_nettype wire

[src/fua_if.sv]
// Stream interfaces for NAL descriptors in and packet descriptors out.
`default_nettype none

interface fua_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  nal_header;
  logic [15:0] nal_length;
  logic [31:0] rtp_time;

  modport source (output valid, op, nal_header, nal_length, rtp_time, input ready);
  modport sink   (input valid, op, nal_header, nal_length, rtp_time, output ready);
endinterface

interface fua_out_if;
  logic        valid;
  logic        ready;
  logic        is_fragment;
  logic [7:0]  fu_indicator;
  logic [7:0]  fu_header;
  logic [15:0] source_offset;
  logic [16:0] packet_length;
  logic [31:0] packet_time;
  logic        marker;
  logic        last_of_run;

  modport source (output valid, is_fragment, fu_indicator, fu_header, source_offset,
                  packet_length, packet_time, marker, last_of_run, input ready);
  modport sink   (input valid, is_fragment, fu_indicator, fu_header, source_offset,
                  packet_length, packet_time, marker, last_of_run, output ready);
endinterface

`default_nettype wire

[src/h264_fua_rtp_fragmenter.sv]
// H.264 FU-A RTP fragmenter top level: config register, front, queue, back.
// A held NAL is released as a job when the next descriptor or a flush is
//   transferred; the back end registers the job and, for a fragmented NAL,
//   works out the stride (reciprocal multiply, then clamp) before it emits.
// Throughput: fragments leave one a cycle while out_ch is ready, at most
//   MAX_FRAGMENTS per NAL; the back end takes a new job only after its run.
// Reset (rst, synchronous): empties the hold and queue, max_payload to 1400.
`default_nettype none

module h264_fua_rtp_fragmenter #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  fua_in_if.sink           in_ch,
  fua_out_if.source        out_ch
);
  import fua_pkg::*;

  // Stride register; the user must write it only while the block is idle, which the block does not enforce
  logic [15:0] max_payload;

  // Front -> queue -> back plumbing
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  // Front: keeps one NAL back so the marker can be decided from its successor
  fua_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Two-entry queue so descriptors keep flowing while a long run is emitted
  fua_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  // Back: stride for fragments, then one packet per transfer from a registered output
  fua_back #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_payload (max_payload),
    .q_rd        (q_rd),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

[src/fua_front.sv]
// Front end: holds the last NAL descriptor and releases it as a job.
`default_nettype none

module fua_front (
  input  wire logic       clk,
  input  wire logic       rst,
  fua_in_if.sink          in_ch,
  input  wire logic       q_full,
  output fua_pkg::q_wr_t  q_wr
);
  import fua_pkg::*;

  logic        held_valid;
  logic [7:0]  held_header;
  logic [15:0] held_length;
  logic [31:0] held_timestamp;
  logic        in_xfer;

  assign in_ch.ready = !q_full;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    q_wr.en            = in_xfer && held_valid;
    q_wr.job.header    = held_header;
    q_wr.job.length    = held_length;
    q_wr.job.timestamp = held_timestamp;
    // end of access unit when the timestamp moves on; never on flush
    q_wr.job.mark      = (op_t'(in_ch.op) == OP_NEW) && (in_ch.rtp_time != held_timestamp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_header    <= '0;
      held_length    <= '0;
      held_timestamp <= '0;
    end else if (in_xfer) begin
      unique case (op_t'(in_ch.op))
        OP_FLUSH: begin
          held_valid     <= 1'b0;
          held_header    <= '0;
          held_length    <= '0;
          held_timestamp <= '0;
        end
        OP_NEW: begin
          held_valid     <= 1'b1;
          held_header    <= in_ch.nal_header;
          held_length    <= in_ch.nal_length;
          held_timestamp <= in_ch.rtp_time;
        end
        default: ;
      endcase
    end
  end

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (op_t'(in_ch.op) == OP_FLUSH) |=> !held_valid && (held_length == '0))
    else $error("hold not emptied after flush");

endmodule

`default_nettype wire

[src/fua_queue.sv]
// Short job queue between the front and back ends.
`default_nettype none

module fua_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire fua_pkg::q_wr_t q_wr,
  output logic            q_full,
  input  wire logic       pop,
  output fua_pkg::q_rd_t  q_rd
);
  import fua_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.job   = slots[rd_ptr];
  assign do_push   = q_wr.en && !q_full;
  assign do_pop    = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr.en |-> !q_full)
    else $error("job pushed into full queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count out of step");

endmodule

`default_nettype wire

[src/fua_back.sv]
// Back end: turns one job into a single packet or a run of FU-A fragments.
`default_nettype none

module fua_back #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] max_payload,
  input  wire fua_pkg::q_rd_t q_rd,
  output logic             pop,
  fua_out_if.source        out_ch
);
  import fua_pkg::*;

  localparam int DIV_K   = 17;
  localparam int DIV_L   = $clog2(MAX_FRAGMENTS);
  localparam int DIV_S   = DIV_K + DIV_L;
  localparam int RECIP_W = DIV_K + 2;
  localparam int PROD_W  = DIV_S + 16;
  localparam int FC_W    = $clog2(MAX_FRAGMENTS);
  // ceil(2^S / N): exact floor division by N for any 17-bit dividend
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_S) + MAX_FRAGMENTS - 1) / MAX_FRAGMENTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STRIDE,
    ST_EMIT
  } state_t;

  state_t            state;
  job_t              job;
  logic              single;
  logic [15:0]       stride;
  logic [15:0]       off;
  logic [16:0]       dq;
  logic [15:0]       min_stride;
  logic [FC_W-1:0]   frag_cnt;
  logic              out_valid;

  logic              slot_free;
  logic              emit_now;
  logic              head_single;
  logic [PROD_W-1:0] prod;
  logic [16:0]       end_sum;
  logic              first;
  logic              last;
  logic [15:0]       plen;

  assign slot_free    = !out_valid || out_ch.ready;
  assign emit_now     = (state == ST_EMIT) && slot_free;
  assign out_ch.valid = out_valid;
  assign pop          = (state == ST_IDLE) && q_rd.valid;
  assign head_single  = (q_rd.job.length <= max_payload) || (q_rd.job.length <= 16'd1);

  // (len + N - 1) / N by reciprocal multiplication
  assign prod = {{(PROD_W-17){1'b0}}, dq} * {{(PROD_W-RECIP_W){1'b0}}, RECIP};

  assign end_sum = {1'b0, off} + {1'b0, stride};
  assign first   = (off == '0);
  assign last    = (end_sum >= {1'b0, job.length});
  assign plen    = last ? (job.length - off) : (stride - {15'd0, first});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      single    <= 1'b0;
      frag_cnt  <= '0;
    end else begin
      out_valid <= emit_now || (out_valid && !out_ch.ready);
      unique case (state)
        ST_IDLE: begin
          if (q_rd.valid) begin
            job      <= q_rd.job;
            single   <= head_single;
            off      <= '0;
            frag_cnt <= '0;
            dq       <= {1'b0, q_rd.job.length} + 17'(MAX_FRAGMENTS - 1);
            state    <= head_single ? ST_EMIT : ST_DIV;
          end
        end
        ST_DIV: begin
          min_stride <= prod[DIV_S +: 16];
          state      <= ST_STRIDE;
        end
        ST_STRIDE: begin
          stride <= (max_payload < min_stride) ? min_stride : max_payload;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_ch.packet_time <= job.timestamp;
            if (single) begin
              out_ch.is_fragment   <= 1'b0;
              out_ch.fu_indicator  <= '0;
              out_ch.fu_header     <= '0;
              out_ch.source_offset <= '0;
              out_ch.packet_length <= {1'b0, job.length};
              out_ch.marker        <= job.mark;
              out_ch.last_of_run   <= 1'b1;
              state                <= ST_IDLE;
            end else begin
              out_ch.is_fragment   <= 1'b1;
              out_ch.fu_indicator  <= {job.header[7:5], FU_A_TYPE};
              out_ch.fu_header     <= (first ? S_BIT : (last ? E_BIT : 8'h00))
                                      | {3'b000, job.header[4:0]};
              out_ch.source_offset <= first ? 16'd1 : off;
              out_ch.packet_length <= {1'b0, plen} + 17'd2;
              out_ch.marker        <= last && job.mark;
              out_ch.last_of_run   <= last;
              if (last) begin
                state <= ST_IDLE;
              end else begin
                off      <= end_sum[15:0];
                frag_cnt <= frag_cnt + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_frag_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !single && slot_free && (frag_cnt == FC_W'(MAX_FRAGMENTS - 1))
    |-> last)
    else $error("fragment run exceeds limit");

  a_off_in_nal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !single |-> off < job.length)
    else $error("fragment offset past end of NAL");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != ST_IDLE)
    else $error("job taken without starting work");

endmodule

`default_nettype wire

[tb/fua_packet_checker.sv]
// Packet checker for the FU-A fragmenter: predicts packet descriptors and compares them.
`timescale 1ns / 100ps

module fua_packet_checker #(
  parameter int FRAG_LIMIT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  fua_in_if                nal_mon,
  fua_out_if               pkt_mon,
  output int               mismatches,
  output int               packets_due,
  output int               packets_seen,
  output int               fragments_seen
);
  import fua_pkg::*;

  typedef struct packed {
    logic        is_fragment;
    logic [7:0]  fu_indicator;
    logic [7:0]  fu_header;
    logic [15:0] source_offset;
    logic [16:0] packet_length;
    logic [31:0] packet_time;
    logic        marker;
    logic        last_of_run;
  } pkt_t;

  pkt_t        expected_pkts[$];
  logic [15:0] max_payload;
  logic        held_valid;
  logic [7:0]  held_header;
  logic [15:0] held_length;
  logic [31:0] held_time;
  int          error_tally;
  int          seen_tally;
  int          frag_tally;

  function automatic string pkt_text(pkt_t p);
    return $sformatf("frag=%0b ind=%02h hdr=%02h off=%0d len=%0d time=%08h mark=%0b last=%0b",
                     p.is_fragment, p.fu_indicator, p.fu_header, p.source_offset,
                     p.packet_length, p.packet_time, p.marker, p.last_of_run);
  endfunction

  // append one predicted packet at the tail
  function automatic void queue_expected(pkt_t p);
    expected_pkts.insert(expected_pkts.size(), p);
  endfunction

  task automatic note_mismatch(input string msg);
    error_tally++;
    if (error_tally <= 10)
      $display("%0t: packet mismatch: %s", $time, msg);
  endtask

  // Turn the held NAL into one single packet or a run of FU-A fragments
  task automatic release_held_nal(input logic mark);
    int unsigned len;
    int unsigned mp;
    int unsigned stride;
    int unsigned min_stride;
    int unsigned off;
    int unsigned plen;
    int          n;
    logic        first;
    logic        last;
    pkt_t        p;
    len = held_length;
    mp  = max_payload;
    p   = '0;
    p.packet_time = held_time;
    if (len <= mp || len <= 1) begin
      p.packet_length = 17'(len);
      p.marker        = mark;
      p.last_of_run   = 1'b1;
      queue_expected(p);
    end else begin
      // stride is widened when the fragment count would overflow
      min_stride = (len + FRAG_LIMIT - 1) / FRAG_LIMIT;
      stride     = (mp < min_stride) ? min_stride : mp;
      off        = 0;
      n          = 0;
      while (off < len && n < FRAG_LIMIT) begin
        first = (off == 0);
        last  = (off + stride >= len);
        plen  = last ? (len - off) : (stride - (first ? 1 : 0));
        p.is_fragment   = 1'b1;
        p.fu_indicator  = {held_header[7:5], FU_A_TYPE};
        p.fu_header     = (first ? S_BIT : (last ? E_BIT : 8'h00)) |
                          {3'b000, held_header[4:0]};
        p.source_offset = first ? 16'd1 : 16'(off);
        p.packet_length = 17'(plen + 2);
        p.marker        = last && mark;
        p.last_of_run   = last || (n == FRAG_LIMIT - 1);
        queue_expected(p);
        off += stride;
        n++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    pkt_t got;
    pkt_t want;
    if (rst) begin
      expected_pkts.delete();
      max_payload = MAX_PAYLOAD_RESET;
      held_valid  = 1'b0;
      held_header = '0;
      held_length = '0;
      held_time   = '0;
      error_tally = 0;
      seen_tally  = 0;
      frag_tally  = 0;
    end else begin
      if (pkt_mon.valid && pkt_mon.ready) begin
        got.is_fragment   = pkt_mon.is_fragment;
        got.fu_indicator  = pkt_mon.fu_indicator;
        got.fu_header     = pkt_mon.fu_header;
        got.source_offset = pkt_mon.source_offset;
        got.packet_length = pkt_mon.packet_length;
        got.packet_time   = pkt_mon.packet_time;
        got.marker        = pkt_mon.marker;
        got.last_of_run   = pkt_mon.last_of_run;
        seen_tally++;
        if (got.is_fragment === 1'b1)
          frag_tally++;
        if (expected_pkts.size() == 0) begin
          note_mismatch({"unexpected packet ", pkt_text(got)});
        end else begin
          want = expected_pkts.pop_front();
          if (got !== want)
            note_mismatch({"expected ", pkt_text(want), " got ", pkt_text(got)});
        end
      end
      if (cfg_wr_en)
        max_payload = cfg_wr_data;
      if (nal_mon.valid && nal_mon.ready) begin
        if (nal_mon.op == OP_FLUSH) begin
          if (held_valid) begin
            release_held_nal(1'b0);
            held_valid  = 1'b0;
            held_header = '0;
            held_length = '0;
            held_time   = '0;
          end
        end else begin
          if (held_valid)
            release_held_nal(nal_mon.rtp_time != held_time);
          held_valid  = 1'b1;
          held_header = nal_mon.nal_header;
          held_length = nal_mon.nal_length;
          held_time   = nal_mon.rtp_time;
        end
      end
    end
    mismatches     <= error_tally;
    packets_due    <= expected_pkts.size();
    packets_seen   <= seen_tally;
    fragments_seen <= frag_tally;
  end

endmodule

[tb/tb_h264_fua_rtp_fragmenter.sv]
// Testbench top for the FU-A fragmenter: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_h264_fua_rtp_fragmenter;
  import fua_pkg::*;

  localparam int FRAG_LIMIT       = 64;
  // worst back-end run is a full 64-fragment NAL; leave room for sink gaps on top
  localparam int DRAIN_CYCLES     = 120;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int AU_TIME_STEP     = 3000;  // 90 kHz clock at 30 frames/s

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  fua_in_if  nal_ch ();
  fua_out_if pkt_ch ();

  int mismatches;
  int packets_due;
  int packets_seen;
  int fragments_seen;

  // stimulus control, shared with the sink process
  bit          src_gaps_on;
  bit          sink_gaps_on;
  int          sink_hold;
  int          nals_sent;
  int          flushes_sent;
  int          cfg_writes;
  logic [15:0] cur_max_payload;
  logic [31:0] cur_time;

  h264_fua_rtp_fragmenter #(
    .MAX_FRAGMENTS(FRAG_LIMIT)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (nal_ch),
    .out_ch     (pkt_ch)
  );

  fua_packet_checker #(
    .FRAG_LIMIT(FRAG_LIMIT)
  ) packet_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .nal_mon       (nal_ch),
    .pkt_mon       (pkt_ch),
    .mismatches    (mismatches),
    .packets_due   (packets_due),
    .packets_seen  (packets_seen),
    .fragments_seen(fragments_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every NAL at 64 fragments)
  initial begin
    #4_000_000;
    $display("tb_h264_fua_rtp_fragmenter failed");
    $finish;
  end

  // Packet sink: random stalls, plus a long hold-off on request.
  // The hold-off is counted down here so the sender keeps running meanwhile.
  initial begin
    out_ready_init : begin
      pkt_ch.ready = 1'b0;
    end
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        pkt_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        pkt_ch.ready <= !(sink_gaps_on && $urandom_range(99) < 6);
      end
    end
  end

  // One descriptor transfer. Valid is left high on return so back-to-back
  // items go out with no bubble; random gaps drop it before an item.
  task automatic send_nal(input op_t op, input logic [7:0] hdr, input logic [15:0] len,
                          input logic [31:0] ts);
    while (src_gaps_on && $urandom_range(99) < 6) begin
      nal_ch.valid <= 1'b0;
      @(posedge clk);
    end
    nal_ch.valid      <= 1'b1;
    nal_ch.op         <= op;
    nal_ch.nal_header <= hdr;
    nal_ch.nal_length <= len;
    nal_ch.rtp_time   <= ts;
    do @(posedge clk); while (!nal_ch.ready);
    if (op == OP_FLUSH)
      flushes_sent++;
    else
      nals_sent++;
  endtask

  // Sender goes quiet until the checker owes nothing, then lets the back end
  // finish any work that yields no packet.
  task automatic wait_drained(input int settle);
    nal_ch.valid <= 1'b0;
    do @(posedge clk); while (packets_due != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [15:0] value);
    wait_drained(DRAIN_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    cur_max_payload  = value;
    cfg_writes++;
  endtask

  // Mostly single packets and modest fragment runs; a few long NALs so the
  // 64-fragment ceiling and the widened stride still get hit.
  function automatic logic [15:0] pick_nal_length();
    int unsigned mp;
    int unsigned upper;
    int          sel;
    mp  = cur_max_payload;
    sel = $urandom_range(99);
    if (sel < 5)
      return 16'($urandom_range(2, 0));
    if (mp >= 65535 || sel < 45)
      return 16'($urandom_range(mp, 1));
    upper = (mp * 8 > 65535) ? 65535 : mp * 8;
    if (sel < 92)
      return 16'($urandom_range(upper, mp + 1));
    return 16'($urandom_range(65535, mp + 1));
  endfunction

  // Access units: NALs share a timestamp, which steps on now and then, so
  // the marker toggles naturally. Flushes carry junk in the unused fields.
  task automatic send_random_nals(input int count);
    int k;
    int sel;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 6) begin
        send_nal(OP_FLUSH, 8'($urandom), 16'($urandom), $urandom);
      end else begin
        sel = $urandom_range(99);
        if (sel < 3)
          cur_time = $urandom;
        else if (sel < 35)
          cur_time = cur_time + AU_TIME_STEP;
        send_nal(OP_NEW, 8'($urandom), pick_nal_length(), cur_time);
      end
    end
  endtask

  // Directed opening at the reset max_payload of 1400
  task automatic send_directed();
    send_nal(OP_FLUSH, 8'h00, 16'd0,     32'h0);         // flush with nothing held
    send_nal(OP_NEW,   8'h65, 16'd1400,  32'h0);         // first NAL only held
    send_nal(OP_NEW,   8'h41, 16'd1401,  32'h0);         // 1400 single, same AU
    send_nal(OP_NEW,   8'hFF, 16'd0,     32'h1);         // 1401 splits in two, marker
    send_nal(OP_NEW,   8'h00, 16'd1,     32'h1);         // zero length stays single
    send_nal(OP_NEW,   8'h7C, 16'd65535, 32'hFFFF_FFFF); // one-byte NAL single
    send_nal(OP_NEW,   8'h9E, 16'd2,     32'hFFFF_FFFF); // longest NAL, no marker
    send_nal(OP_FLUSH, 8'h00, 16'd0,     32'h0);         // flush: marker forced low
    send_nal(OP_FLUSH, 8'hFF, 16'hFFFF,  32'hFFFF_FFFF); // second flush gives nothing
    send_nal(OP_NEW,   8'h67, 16'd2800,  32'd100);
    send_nal(OP_NEW,   8'h68, 16'd2801,  32'd100);       // 2800 ends on a stride edge
    send_nal(OP_NEW,   8'h06, 16'd4200,  32'd200);       // 2801 spills to a third
    send_nal(OP_FLUSH, 8'h5A, 16'd7,     32'h55);        // ignored fields on flush
    send_nal(OP_NEW,   8'hE5, 16'd1402,  32'd300);
    send_nal(OP_NEW,   8'h21, 16'd100,   32'd301);
    send_nal(OP_NEW,   8'h1C, 16'd32768, 32'd301);
    send_nal(OP_NEW,   8'h80, 16'd1399,  32'd302);
    send_nal(OP_FLUSH, 8'hAA, 16'd9999,  32'hAAAA_5555);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    nal_ch.valid       = 1'b0;
    nal_ch.op          = OP_NEW;
    nal_ch.nal_header  = '0;
    nal_ch.nal_length  = '0;
    nal_ch.rtp_time    = '0;
    src_gaps_on        = 1'b1;
    sink_gaps_on       = 1'b1;
    sink_hold          = 0;
    nals_sent          = 0;
    flushes_sent       = 0;
    cfg_writes         = 0;
    cur_max_payload    = MAX_PAYLOAD_RESET;
    cur_time           = 32'hFFFF_0000;  // wraps early in the run
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_directed();

    // 1024, the top of the register range, then 512 where the stride must
    // widen to stay within 64 fragments, then a random value in between
    set_max_payload(16'd1024);
    send_random_nals(70);
    set_max_payload(16'hFFFF);
    send_random_nals(60);
    set_max_payload(16'd512);
    send_random_nals(60);
    set_max_payload(16'($urandom_range(65534, 1025)));
    send_random_nals(70);
    set_max_payload(MAX_PAYLOAD_RESET);

    // Long sink hold-off while descriptors keep coming: the hold and the job
    // queue fill and the input stalls. Then the sender waits for every packet.
    sink_hold = LONG_HOLD_CYCLES;
    send_random_nals(30);
    wait_drained(0);

    // flat-out stretch, no gaps on either side
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    send_random_nals(60);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;

    send_nal(OP_FLUSH, 8'h00, 16'd0, 32'h0);
    wait_drained(DRAIN_CYCLES);

    $display("run covered %0d NAL descriptors and %0d flushes over %0d max_payload writes",
             nals_sent, flushes_sent, cfg_writes);
    $display("%0d packet transfers checked, %0d of them FU-A fragments",
             packets_seen, fragments_seen);
    if (mismatches == 0 && packets_due == 0)
      $display("tb_h264_fua_rtp_fragmenter passed");
    else
      $display("tb_h264_fua_rtp_fragmenter failed");
    $finish;
  end

endmodule

[files.f]
src/fua_pkg.sv
src/fua_if.sv
src/fua_front.sv
src/fua_queue.sv
src/fua_back.sv
src/h264_fua_rtp_fragmenter.sv
tb/fua_packet_checker.sv
tb/tb_h264_fua_rtp_fragmenter.sv
